[rtl/plp_pkg.sv]
// Shared constants, codes and helper functions for the piecewise-linear penalty block.
package plp_pkg;

  localparam int VAL_W = 48;
  localparam int DEN_W = 49;
  localparam int NUM_W = 98;
  localparam int OP_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 28;
  localparam int MUL_STEPS = 49;

  localparam logic [OP_W-1:0] OP_LOOKUP      = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_DERIV   = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR_DERIV = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE_POINT = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_DERIV  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TRANSFORM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_SCORE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS    = 3'd4;

  localparam logic [2:0] TR_LN     = 3'd1;
  localparam logic [2:0] TR_LN_P1  = 3'd2;
  localparam logic [2:0] TR_LN_P3  = 3'd3;
  localparam logic [2:0] TR_PLUS3  = 3'd4;

  localparam logic signed [VAL_W-1:0] ONE_Q16 = 48'sd65536;
  localparam logic signed [DEN_W-1:0] ONE_Q16_W = 49'sd65536;
  localparam logic signed [DEN_W-1:0] THREE_Q16_W = 49'sd196608;
  localparam logic signed [VAL_W-1:0] MAX48 = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] MIN48 = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [39:0] LN2_Q40 = 40'd762123384786;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  function automatic logic signed [VAL_W-1:0] sat48(input logic signed [DEN_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > $signed({MAX48[VAL_W-1], MAX48})) r = MAX48;
    else if (v < $signed({MIN48[VAL_W-1], MIN48})) r = MIN48;
    else r = v[VAL_W-1:0];
    return r;
  endfunction

  function automatic logic [DEN_W-1:0] mag49(input logic signed [DEN_W-1:0] v);
    logic [DEN_W-1:0] r;
    r = v[DEN_W-1] ? DEN_W'(-v) : DEN_W'(v);
    return r;
  endfunction

endpackage

[rtl/plp_if.sv]
// Request and response channel interfaces of the piecewise-linear penalty block.
interface plp_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [27:0] position;
  logic signed [47:0] score;
  logic [3:0]         point_index;
  logic signed [47:0] limit_value;
  logic signed [47:0] penalty_value;
  modport source (output valid, operation, position, score, point_index, limit_value,
                  penalty_value, input ready);
  modport sink (input valid, operation, position, score, point_index, limit_value,
                penalty_value, output ready);
endinterface

interface plp_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] penalty;
  logic               minus_infinity;
  logic signed [47:0] derivative;
  modport source (output valid, penalty, minus_infinity, derivative, input ready);
  modport sink (input valid, penalty, minus_infinity, derivative, output ready);
endinterface

[rtl/plp_div.sv]
// Restoring signed divider, one quotient bit per cycle, saturating to 48 bits.
module plp_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [plp_pkg::NUM_W-1:0]     num,
  input  logic signed [plp_pkg::DEN_W-1:0]     den,
  output logic                                 done,
  output logic signed [plp_pkg::VAL_W-1:0]     quo
);
  import plp_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] dividend;
  logic [DEN_W-1:0] dmag;
  logic [DEN_W-1:0] rem;
  logic [VAL_W:0]   q;
  logic             ovf;
  logic             neg;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  always_comb begin
    rem_sh = {rem, dividend[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, dmag};
    fits = (rem_sh >= {1'b0, dmag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dmag <= mag49(den);
      rem <= '0;
      q <= '0;
      ovf <= 1'b0;
      neg <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy) begin
      dividend <= {dividend[NUM_W-2:0], 1'b0};
      rem <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      // Quotient bits that leave the top only matter as an overflow mark.
      q <= {q[VAL_W-1:0], fits};
      ovf <= ovf | q[VAL_W];
    end
  end

  always_comb begin
    if (!neg) begin
      quo = (ovf || q > {2'b00, {(VAL_W-1){1'b1}}}) ? MAX48 : q[VAL_W-1:0];
    end else begin
      quo = (ovf || q > {2'b01, {(VAL_W-1){1'b0}}}) ? MIN48 : VAL_W'(-q);
    end
  end

endmodule

[rtl/plp_ln.sv]
// Iterative natural log of a positive Q16 value, rounded to Q16; else MIN48.
module plp_ln (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [plp_pkg::VAL_W:0]   arg,
  output logic                             done,
  output logic signed [plp_pkg::VAL_W-1:0] res
);
  import plp_pkg::*;

  typedef enum logic [5:0] {
    L_IDLE = 6'b000001,
    L_NORM = 6'b000010,
    L_SQ   = 6'b000100,
    L_MUL  = 6'b001000,
    L_SUM  = 6'b010000,
    L_RND  = 6'b100000
  } ln_state_t;

  ln_state_t               state;
  logic [VAL_W-1:0]        u;
  logic [5:0]              sh;
  logic [30:0]             m;
  logic [29:0]             f;
  logic [4:0]              k;
  logic [59:0]             pr;
  logic signed [VAL_W-1:0] s;
  logic [61:0]             sq;
  logic [31:0]             t;
  logic signed [6:0]       pe;
  logic signed [VAL_W-1:0] pe_term;

  always_comb begin
    sq = 62'(m) * 62'(m);
    t = sq[61:30];
    pe = 7'sd31 - $signed({1'b0, sh});
    pe_term = VAL_W'(pe) * VAL_W'($signed({1'b0, LN2_Q40}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (start) begin
            if (arg[VAL_W] || arg == '0) begin
              res <= MIN48;
              done <= 1'b1;
            end else begin
              u <= arg[VAL_W-1:0];
              sh <= '0;
              state <= L_NORM;
            end
          end
        end
        L_NORM: begin
          // Move the leading one to the top, a byte at a time while we can.
          if (u[VAL_W-1]) begin
            m <= u[VAL_W-1:VAL_W-31];
            f <= '0;
            k <= '0;
            state <= L_SQ;
          end else if (u[VAL_W-1:VAL_W-8] == '0) begin
            u <= {u[VAL_W-9:0], 8'h00};
            sh <= sh + 6'd8;
          end else begin
            u <= {u[VAL_W-2:0], 1'b0};
            sh <= sh + 6'd1;
          end
        end
        L_SQ: begin
          m <= t[31] ? t[31:1] : t[30:0];
          f <= {f[28:0], t[31]};
          k <= k + 1'b1;
          if (k == 5'd29) state <= L_MUL;
        end
        L_MUL: begin
          pr <= 60'(f) * 60'(LN2_Q30);
          state <= L_SUM;
        end
        L_SUM: begin
          s <= pe_term + $signed({8'b0, pr[59:20]});
          state <= L_RND;
        end
        L_RND: begin
          res <= (s + 48'sd8388608) >>> 24;
          done <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

[rtl/piecewise_linear_penalty.sv]
// Top level of the piecewise-linear penalty block: sequencer, tables and accumulators.
//
// Requests arrive on req (valid/ready); each produces exactly one response on rsp.
// The block works on one request at a time: ready is high only while the sequencer
// is idle. A finished response sits in an output register, so the next request is
// taken while the previous response still waits for rsp.ready.
// Work per request:
//   write point, clear derivatives, out-of-range or unknown operation: done at once.
//   read derivative: an accumulator read.
//   lookup or add derivative: transform (ln: normalize, square, sum, round),
//   then a scan over the limit memory (n points in use), then either an end penalty
//   or end accumulator update at a table end, or fetch states plus two 49-step serial
//   multiplies and a 98-step divide for a lookup, or two 98-step divides with
//   accumulator updates for add derivative.
// The serial multiplier and the one-bit-per-cycle divider dominate an interpolation.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the user
// must do so only while idle; the block does not enforce it. Reset (rst, synchronous)
// sets state, rsp.valid and configuration to defaults and zeroes derivative accumulators
// at once via per-entry valid bits; the breakpoint tables hold garbage until written.
module piecewise_linear_penalty #(
  parameter int MAX_POINTS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  plp_req_if.sink                            req,
  plp_rsp_if.source                          rsp,
  input  logic                               cfg_we,
  input  logic [plp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [plp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import plp_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_LOG    = 15'b000000000000010,
    S_SCAN   = 15'b000000000000100,
    S_SEG    = 15'b000000000001000,
    S_FETCH  = 15'b000000000010000,
    S_LOAD   = 15'b000000000100000,
    S_CHOOSE = 15'b000000001000000,
    S_MUL    = 15'b000000010000000,
    S_DIVGO  = 15'b000000100000000,
    S_DIV    = 15'b000001000000000,
    S_ACC_RD = 15'b000010000000000,
    S_ACC_WR = 15'b000100000000000,
    S_READ   = 15'b001000000000000,
    S_END    = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [2:0]         transform_mode;
  logic signed [27:0] min_position;
  logic signed [27:0] max_position;
  logic               use_score;
  logic [4:0]         point_count;

  // Tables and accumulators.
  logic signed [VAL_W-1:0] lim_mem [MAX_POINTS];
  logic signed [VAL_W-1:0] pen_mem [MAX_POINTS];
  logic signed [VAL_W-1:0] acc_mem [MAX_POINTS];
  logic [MAX_POINTS-1:0]   acc_vld;
  logic signed [VAL_W-1:0] lim_q;
  logic signed [VAL_W-1:0] pen_q;
  logic signed [VAL_W-1:0] acc_q;
  logic                    accv_q;

  // Working registers.
  logic [OP_W-1:0]         op;
  logic signed [VAL_W-1:0] x;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           idx;
  logic signed [VAL_W-1:0] l0, l1, p0, p1;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        mreg;
  logic [DEN_W-1:0]        mb;
  logic                    msign;
  logic [5:0]              mcnt;
  logic                    phase;
  logic                    interp;
  logic [IW-1:0]           acc_idx;
  logic signed [VAL_W-1:0] w;
  logic signed [VAL_W-1:0] res_pen;
  logic                    res_minf;
  logic signed [VAL_W-1:0] res_der;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_pen;
  logic                    out_minf;
  logic signed [VAL_W-1:0] out_der;

  // Combinational helpers.
  logic                    accept;
  logic [CW-1:0]           n;
  logic                    pi_ok;
  logic [IW-1:0]           pi_addr;
  logic signed [VAL_W-1:0] xin;
  logic signed [DEN_W-1:0] xa;
  logic signed [VAL_W-1:0] x_lin;
  logic                    in_ok;
  logic                    use_log;
  logic                    ln_start;
  logic                    ln_done;
  logic signed [VAL_W-1:0] ln_res;
  logic [IW-1:0]           tab_addr;
  logic [IW-1:0]           acc_addr;
  logic [IW-1:0]           end_addr;
  logic [IW-1:0]           lo_addr;
  logic signed [DEN_W-1:0] dh, dl, den;
  logic signed [VAL_W-1:0] acc_base;
  logic signed [VAL_W-1:0] acc_sum;
  logic                    tab_we;
  logic                    acc_we;
  logic                    div_done;
  logic signed [VAL_W-1:0] quo;
  logic                    is_lookup;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.penalty = out_pen;
  assign rsp.minus_infinity = out_minf;
  assign rsp.derivative = out_der;
  assign is_lookup = (op == OP_LOOKUP);

  always_comb begin
    if (point_count == '0) n = CW'(1);
    else if (32'(point_count) > MAX_POINTS) n = CW'(MAX_POINTS);
    else n = CW'(point_count);
    pi_ok = (32'(req.point_index) < MAX_POINTS);
    pi_addr = IW'(req.point_index);

    xin = use_score ? req.score : {{4{req.position[27]}}, req.position, 16'h0000};
    in_ok = use_score || (req.position >= min_position && req.position <= max_position);
    case (transform_mode)
      TR_LN_P1: xa = {xin[VAL_W-1], xin} + ONE_Q16_W;
      TR_LN_P3, TR_PLUS3: xa = {xin[VAL_W-1], xin} + THREE_Q16_W;
      default: xa = {xin[VAL_W-1], xin};
    endcase
    x_lin = (transform_mode == TR_PLUS3) ? sat48(xa) : xin;
    use_log = (transform_mode == TR_LN) || (transform_mode == TR_LN_P1) ||
              (transform_mode == TR_LN_P3);
    ln_start = accept && in_ok && use_log &&
               (req.operation == OP_LOOKUP || req.operation == OP_ADD_DERIV);

    end_addr = (idx == '0) ? '0 : IW'(n - 1'b1);
    lo_addr = IW'(idx - 1'b1);
    case (state)
      S_SCAN: tab_addr = cnt[IW-1:0];
      S_SEG: tab_addr = (idx == '0 || idx == n) ? end_addr : lo_addr;
      S_FETCH: tab_addr = IW'(idx);
      default: tab_addr = '0;
    endcase
    acc_addr = (state == S_IDLE) ? pi_addr : acc_idx;

    dh = {x[VAL_W-1], x} - {l0[VAL_W-1], l0};
    dl = {l1[VAL_W-1], l1} - {x[VAL_W-1], x};
    den = {l1[VAL_W-1], l1} - {l0[VAL_W-1], l0};

    acc_base = accv_q ? acc_q : '0;
    acc_sum = sat48({acc_base[VAL_W-1], acc_base} + {w[VAL_W-1], w});

    tab_we = accept && req.operation == OP_WRITE_POINT && pi_ok;
    acc_we = (state == S_ACC_WR);
  end

  plp_ln u_ln (
    .clk  (clk),
    .rst  (rst),
    .start(ln_start),
    .arg  (xa),
    .done (ln_done),
    .res  (ln_res)
  );

  plp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(state == S_DIVGO),
    .num  (num),
    .den  (den),
    .done (div_done),
    .quo  (quo)
  );

  always_ff @(posedge clk) begin
    if (tab_we) begin
      lim_mem[pi_addr] <= req.limit_value;
      pen_mem[pi_addr] <= req.penalty_value;
    end
    lim_q <= lim_mem[tab_addr];
    pen_q <= pen_mem[tab_addr];
    if (acc_we) acc_mem[acc_idx] <= acc_sum;
    acc_q <= acc_mem[acc_addr];
    accv_q <= acc_vld[acc_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      transform_mode <= '0;
      min_position <= '0;
      max_position <= '0;
      use_score <= 1'b0;
      point_count <= 5'd1;
      acc_vld <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRANSFORM: transform_mode <= cfg_data[2:0];
          CFG_MIN_POS: min_position <= cfg_data;
          CFG_MAX_POS: max_position <= cfg_data;
          CFG_USE_SCORE: use_score <= cfg_data[0];
          CFG_POINTS: point_count <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_valid && rsp.ready) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op <= req.operation;
            res_pen <= '0;
            res_minf <= 1'b0;
            res_der <= '0;
            cnt <= '0;
            idx <= '0;
            case (req.operation)
              OP_LOOKUP, OP_ADD_DERIV: begin
                if (!in_ok) begin
                  res_minf <= (req.operation == OP_LOOKUP);
                  state <= S_DONE;
                end else if (use_log) begin
                  state <= S_LOG;
                end else begin
                  x <= x_lin;
                  state <= S_SCAN;
                end
              end
              OP_CLEAR_DERIV: begin
                for (int i = 0; i < MAX_POINTS; i++) begin
                  if (i < int'(n)) acc_vld[i] <= 1'b0;
                end
                state <= S_DONE;
              end
              OP_READ_DERIV: state <= pi_ok ? S_READ : S_DONE;
              default: state <= S_DONE;
            endcase
          end
        end
        S_LOG: begin
          if (ln_done) begin
            x <= ln_res;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Memory data is read through a register, so entry cnt-1 is compared here.
          if (cnt != '0 && lim_q <= x) idx <= idx + 1'b1;
          if (cnt == n) state <= S_SEG;
          else cnt <= cnt + 1'b1;
        end
        S_SEG: begin
          if (idx == '0 || idx == n) begin
            acc_idx <= end_addr;
            w <= ONE_Q16;
            interp <= 1'b0;
            state <= is_lookup ? S_END : S_ACC_RD;
          end else begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          l0 <= lim_q;
          p0 <= pen_q;
          state <= S_LOAD;
        end
        S_LOAD: begin
          l1 <= lim_q;
          p1 <= pen_q;
          state <= S_CHOOSE;
        end
        S_CHOOSE: begin
          phase <= 1'b0;
          if (den == '0) begin
            // Equal neighboring limits put all the weight on the lower point.
            if (is_lookup) begin
              res_pen <= p0;
              state <= S_DONE;
            end else begin
              acc_idx <= lo_addr;
              w <= ONE_Q16;
              interp <= 1'b0;
              state <= S_ACC_RD;
            end
          end else if (is_lookup) begin
            num <= '0;
            mreg <= NUM_W'(mag49({p1[VAL_W-1], p1}));
            mb <= mag49(dh);
            msign <= p1[VAL_W-1] ^ dh[DEN_W-1];
            mcnt <= '0;
            state <= S_MUL;
          end else begin
            num <= NUM_W'(dh) <<< 16;
            interp <= 1'b1;
            state <= S_DIVGO;
          end
        end
        S_MUL: begin
          if (mb[0]) num <= msign ? num - $signed(mreg) : num + $signed(mreg);
          mreg <= {mreg[NUM_W-2:0], 1'b0};
          mb <= {1'b0, mb[DEN_W-1:1]};
          mcnt <= mcnt + 1'b1;
          if (mcnt == 6'(MUL_STEPS - 1)) begin
            if (!phase) begin
              mreg <= NUM_W'(mag49({p0[VAL_W-1], p0}));
              mb <= mag49(dl);
              msign <= p0[VAL_W-1] ^ dl[DEN_W-1];
              mcnt <= '0;
              phase <= 1'b1;
            end else begin
              state <= S_DIVGO;
            end
          end
        end
        S_DIVGO: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            if (is_lookup) begin
              res_pen <= quo;
              state <= S_DONE;
            end else begin
              w <= quo;
              acc_idx <= phase ? lo_addr : IW'(idx);
              state <= S_ACC_RD;
            end
          end
        end
        S_ACC_RD: state <= S_ACC_WR;
        S_ACC_WR: begin
          acc_vld[acc_idx] <= 1'b1;
          if (interp && !phase) begin
            num <= NUM_W'(dl) <<< 16;
            phase <= 1'b1;
            state <= S_DIVGO;
          end else begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          res_der <= accv_q ? acc_q : '0;
          state <= S_DONE;
        end
        S_END: begin
          res_pen <= pen_q;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_pen <= res_pen;
            out_minf <= res_minf;
            out_der <= res_der;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the piecewise-linear penalty block.
module tb_top;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam longint Q_ONE = 65536;
  localparam longint VMAX = 64'sd140737488355327;
  localparam longint VMIN = -64'sd140737488355328;
  localparam int POS_LIM = 104857600;
  localparam int POINTS = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [2:0]         op;
    logic signed [27:0] pos;
    logic signed [47:0] score;
    logic [3:0]         idx;
    logic signed [47:0] lim;
    logic signed [47:0] pen;
  } penalty_request_t;

  typedef struct {
    logic signed [47:0] penalty;
    logic               minf;
    logic signed [47:0] deriv;
  } penalty_result_t;

  typedef struct {
    penalty_request_t rq;
    bit               typed;
    penalty_result_t  res;
  } directed_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [plp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [plp_pkg::CFG_DATA_W-1:0] cfg_data;

  plp_req_if req_ch();
  plp_rsp_if rsp_ch();

  piecewise_linear_penalty dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow state of the block.
  longint limit_mem[POINTS];
  longint penalty_mem[POINTS];
  longint deriv_acc[POINTS];
  logic [2:0] sh_transform;
  longint sh_min_pos;
  longint sh_max_pos;
  logic sh_use_score;
  logic [4:0] sh_points;

  penalty_result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int sender_idle_pct;
  int recv_stall_pct;
  int hold_seq;
  int hold_seen = 0;
  int hold_cnt = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint clamp48(logic signed [127:0] v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return longint'(v);
  endfunction

  function automatic longint natural_log(longint a);
    longint unsigned u, m, f;
    longint s;
    int p;
    if (a <= 0) return VMIN;
    u = a;
    p = 0;
    f = 0;
    while ((u >> p) > 1) p++;
    m = (p >= 30) ? (u >> (p - 30)) : (u << (30 - p));
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f = f | 1;
      end
    end
    s = longint'(p - 16) * 64'sd762123384786 + longint'((f * 64'd744261118) >> 20);
    return (s + (64'sd1 << 23)) >>> 24;
  endfunction

  function automatic longint transform_arg(longint v);
    case (sh_transform)
      plp_pkg::TR_LN:    return natural_log(v);
      plp_pkg::TR_LN_P1: return natural_log(v + Q_ONE);
      plp_pkg::TR_LN_P3: return natural_log(v + 3 * Q_ONE);
      plp_pkg::TR_PLUS3: return clamp48(v + 3 * Q_ONE);
      default:           return v;
    endcase
  endfunction

  function automatic void acc_add(int i, longint w);
    deriv_acc[i] = clamp48(deriv_acc[i] + w);
  endfunction

  function automatic penalty_result_t predict_penalty(penalty_request_t r);
    penalty_result_t res;
    int n, seg, e;
    longint x, l0, l1, den;
    logic signed [127:0] num, wden;
    bit ok;
    res.penalty = '0;
    res.minf = 1'b0;
    res.deriv = '0;
    n = (sh_points < 1) ? 1 : (sh_points > POINTS) ? POINTS : int'(sh_points);
    case (r.op)
      plp_pkg::OP_LOOKUP, plp_pkg::OP_ADD_DERIV: begin
        ok = 1'b1;
        if (sh_use_score) begin
          x = r.score;
        end else begin
          ok = !(r.pos < sh_min_pos || r.pos > sh_max_pos);
          x = longint'(r.pos) * Q_ONE;
        end
        if (!ok) begin
          if (r.op == plp_pkg::OP_LOOKUP) res.minf = 1'b1;
        end else begin
          x = transform_arg(x);
          seg = 0;
          for (int i = 0; i < n; i++) if (limit_mem[i] <= x) seg++;
          if (seg == 0 || seg == n) begin
            e = (seg == 0) ? 0 : n - 1;
            if (r.op == plp_pkg::OP_LOOKUP) res.penalty = penalty_mem[e];
            else acc_add(e, Q_ONE);
          end else begin
            l0 = limit_mem[seg-1];
            l1 = limit_mem[seg];
            den = l1 - l0;
            wden = den;
            if (den == 0) begin
              // Coinciding limits: the lower point takes the whole weight.
              if (r.op == plp_pkg::OP_LOOKUP) res.penalty = penalty_mem[seg-1];
              else acc_add(seg - 1, Q_ONE);
            end else if (r.op == plp_pkg::OP_LOOKUP) begin
              num = 128'(signed'(penalty_mem[seg])) * 128'(signed'(x - l0))
                  + 128'(signed'(penalty_mem[seg-1])) * 128'(signed'(l1 - x));
              res.penalty = clamp48(num / wden);
            end else begin
              num = 128'(signed'(x - l0)) * Q_ONE;
              acc_add(seg, clamp48(num / wden));
              num = 128'(signed'(l1 - x)) * Q_ONE;
              acc_add(seg - 1, clamp48(num / wden));
            end
          end
        end
      end
      plp_pkg::OP_CLEAR_DERIV: for (int i = 0; i < n; i++) deriv_acc[i] = 0;
      plp_pkg::OP_WRITE_POINT: begin
        limit_mem[r.idx] = r.lim;
        penalty_mem[r.idx] = r.pen;
      end
      plp_pkg::OP_READ_DERIV: res.deriv = deriv_acc[r.idx];
      default: ;
    endcase
    return res;
  endfunction

  function automatic longint rand48();
    logic signed [47:0] t;
    t = {16'($urandom), $urandom};
    return t;
  endfunction

  function automatic longint rand_span(longint span);
    longint v;
    v = $signed({$urandom, $urandom});
    return v % (span + 1);
  endfunction

  // Sender side: optional gap, then hold the request until the block takes it.
  task automatic send_request(penalty_request_t r, bit typed, penalty_result_t typed_res);
    penalty_result_t res;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.operation <= r.op;
    req_ch.position <= r.pos;
    req_ch.score <= r.score;
    req_ch.point_index <= r.idx;
    req_ch.limit_value <= r.lim;
    req_ch.penalty_value <= r.pen;
    do @(posedge clk); while (!req_ch.ready);
    res = predict_penalty(r);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_block();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_registers(logic [2:0] tr, int mn, int mx, bit sc, logic [4:0] pts);
    cfg_we <= 1'b1;
    cfg_index <= plp_pkg::CFG_TRANSFORM; cfg_data <= 28'(tr); @(posedge clk);
    cfg_index <= plp_pkg::CFG_MIN_POS; cfg_data <= 28'(mn); @(posedge clk);
    cfg_index <= plp_pkg::CFG_MAX_POS; cfg_data <= 28'(mx); @(posedge clk);
    cfg_index <= plp_pkg::CFG_USE_SCORE; cfg_data <= 28'(sc); @(posedge clk);
    cfg_index <= plp_pkg::CFG_POINTS; cfg_data <= 28'(pts); @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sh_transform = tr;
    sh_min_pos = mn;
    sh_max_pos = mx;
    sh_use_score = sc;
    sh_points = pts;
  endtask

  // Receiver side: random stalls, plus a long hold-off when the sender asks for one.
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_cnt <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    penalty_result_t exp_res;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_ch.penalty !== exp_res.penalty) begin
          $error("penalty: expected %0d, got %0d", exp_res.penalty, rsp_ch.penalty);
          errors++;
        end
        if (rsp_ch.minus_infinity !== exp_res.minf) begin
          $error("minus_infinity: expected %0d, got %0d", exp_res.minf,
                 rsp_ch.minus_infinity);
          errors++;
        end
        if (rsp_ch.derivative !== exp_res.deriv) begin
          $error("derivative: expected %0d, got %0d", exp_res.deriv, rsp_ch.derivative);
          errors++;
        end
      end
    end
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic directed_row_t row(logic [2:0] op, int pos, longint score, int idx,
                                        longint lim, longint pen, bit typed,
                                        longint e_pen, bit e_minf, longint e_der);
    directed_row_t d;
    d.rq.op = op;
    d.rq.pos = 28'(pos);
    d.rq.score = 48'(score);
    d.rq.idx = 4'(idx);
    d.rq.lim = 48'(lim);
    d.rq.pen = 48'(pen);
    d.typed = typed;
    d.res.penalty = 48'(e_pen);
    d.res.minf = e_minf;
    d.res.deriv = 48'(e_der);
    return d;
  endfunction

  initial begin
    directed_row_t rows[$];
    penalty_request_t rq;
    penalty_result_t none;
    longint lims[POINTS];
    longint span, tmp;
    logic [2:0] tr;
    int mn, mx, lo, hi;
    bit sc;
    logic [4:0] pts;
    int pick;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.operation = '0;
    req_ch.position = '0;
    req_ch.score = '0;
    req_ch.point_index = '0;
    req_ch.limit_value = '0;
    req_ch.penalty_value = '0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_seq = 0;
    none = '{default: '0};
    for (int i = 0; i < POINTS; i++) begin
      limit_mem[i] = 0;
      penalty_mem[i] = 0;
      deriv_acc[i] = 0;
    end
    sh_transform = '0;
    sh_min_pos = 0;
    sh_max_pos = 0;
    sh_use_score = 1'b0;
    sh_points = 5'd1;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: one point in use, position range is just zero.
    rows.push_back(row(plp_pkg::OP_READ_DERIV, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    rows.push_back(row(plp_pkg::OP_READ_DERIV, 0, 0, 15, 0, 0, 1, 0, 0, 0));
    rows.push_back(row(plp_pkg::OP_WRITE_POINT, 0, 0, 0, VMIN, VMAX, 0, 0, 0, 0));
    rows.push_back(row(plp_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 1, VMAX, 0, 0));
    rows.push_back(row(plp_pkg::OP_LOOKUP, POS_LIM, VMAX, 0, 0, 0, 1, 0, 1, 0));
    rows.push_back(row(plp_pkg::OP_LOOKUP, -POS_LIM, VMIN, 0, 0, 0, 1, 0, 1, 0));
    rows.push_back(row(plp_pkg::OP_ADD_DERIV, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(plp_pkg::OP_READ_DERIV, 0, 0, 0, 0, 0, 1, 0, 0, Q_ONE));
    rows.push_back(row(plp_pkg::OP_ADD_DERIV, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(plp_pkg::OP_READ_DERIV, 0, 0, 0, 0, 0, 1, 0, 0, Q_ONE));
    rows.push_back(row(OP_SPARE_LO, POS_LIM, VMAX, 15, VMAX, VMAX, 1, 0, 0, 0));
    rows.push_back(row(OP_SPARE_HI, -POS_LIM, VMIN, 0, VMIN, VMIN, 1, 0, 0, 0));
    rows.push_back(row(plp_pkg::OP_CLEAR_DERIV, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(plp_pkg::OP_READ_DERIV, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    rows.push_back(row(plp_pkg::OP_WRITE_POINT, 0, 0, 0, VMAX, VMIN, 0, 0, 0, 0));
    rows.push_back(row(plp_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 1, VMIN, 0, 0));
    rows.push_back(row(plp_pkg::OP_ADD_DERIV, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(plp_pkg::OP_READ_DERIV, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(plp_pkg::OP_WRITE_POINT, 0, 0, 15, VMIN, 0, 0, 0, 0, 0));
    foreach (rows[i]) send_request(rows[i].rq, rows[i].typed, rows[i].res);
    drain_block();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin sender_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      tr = (ph < 8) ? 3'(ph) : (ph == 8) ? 3'd0 : plp_pkg::TR_PLUS3;
      sc = $urandom_range(1);
      mn = -$urandom_range(2000);
      mx = $urandom_range(2000);
      pts = 5'($urandom_range(2, POINTS));
      if (ph == 0) pts = 5'd0;
      if (ph == 1) pts = 5'd31;
      if (ph == 2) pts = 5'd1;
      if (ph == 3) pts = 5'(POINTS);
      if (ph == 5) begin
        // Empty range unless both bounds are zero: sc=0 rejects every position.
        tmp = mn; mn = mx; mx = int'(tmp);
      end
      if (ph == 8) begin mn = -POS_LIM; mx = POS_LIM; sc = 1'b0; end
      if (ph == 9) sc = 1'b1;
      write_registers(tr, mn, mx, sc, pts);

      if (tr >= plp_pkg::TR_LN && tr <= plp_pkg::TR_LN_P3) span = 24 * Q_ONE;
      else if (ph >= 8) span = VMAX;
      else if (sc) span = 3000 * Q_ONE;
      else span = 2200 * Q_ONE;
      for (int i = 0; i < POINTS; i++) begin
        lims[i] = ($urandom_range(9) == 0 && i > 0) ? lims[i-1] : rand_span(span);
      end
      for (int i = 1; i < POINTS; i++) begin
        for (int j = i; j > 0 && lims[j-1] > lims[j]; j--) begin
          tmp = lims[j]; lims[j] = lims[j-1]; lims[j-1] = tmp;
        end
      end
      if (ph >= 8) begin lims[0] = VMIN; lims[POINTS-1] = VMAX; end
      for (int i = 0; i < POINTS; i++) begin
        rq = '{default: '0};
        rq.op = plp_pkg::OP_WRITE_POINT;
        rq.idx = 4'(i);
        rq.lim = 48'(lims[i]);
        rq.pen = ($urandom_range(2) == 0) ? 48'(rand48()) : 48'(rand_span(100 * Q_ONE));
        send_request(rq, 1'b0, none);
      end

      lo = (mn < mx ? mn : mx) - 3;
      hi = (mn < mx ? mx : mn) + 3;
      if (lo < -POS_LIM) lo = -POS_LIM;
      if (hi > POS_LIM) hi = POS_LIM;
      for (int k = 0; k < 102; k++) begin
        if (ph == 3 && k == 40) hold_seq++;
        if (ph == 6 && k == 60) drain_block();
        pick = $urandom_range(99);
        rq.op = (pick < 40) ? plp_pkg::OP_LOOKUP :
                (pick < 65) ? plp_pkg::OP_ADD_DERIV :
                (pick < 80) ? plp_pkg::OP_READ_DERIV :
                (pick < 85) ? plp_pkg::OP_CLEAR_DERIV :
                (pick < 92) ? plp_pkg::OP_WRITE_POINT : 3'($urandom_range(5, 7));
        rq.pos = ($urandom_range(99) < 85) ? 28'(lo + int'($urandom_range(hi - lo)))
                                           : 28'(int'($urandom_range(2 * POS_LIM)) - POS_LIM);
        pick = $urandom_range(99);
        if (pick < 55) rq.score = 48'(rand48() >>> $urandom_range(47));
        else if (pick < 90) rq.score = 48'(rand_span(span));
        else case ($urandom_range(4))
          0: rq.score = 48'(VMIN);
          1: rq.score = 48'(VMAX);
          2: rq.score = 48'(0);
          3: rq.score = -48'sd1;
          default: rq.score = 48'(Q_ONE);
        endcase
        rq.idx = 4'($urandom_range(15));
        rq.lim = ($urandom_range(3) == 0) ? 48'(rand48()) : 48'(rand_span(span));
        rq.pen = 48'(rand48());
        send_request(rq, 1'b0, none);
      end
      drain_block();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
